### hw/rtl/wms_pkg.sv
package wms_pkg;

   localparam logic CMD_ADD_BIT   = 1'b0;
   localparam logic CMD_FLUSH_BIT = 1'b1;

   localparam int unsigned REG_WINDOW_LEN = 0;
   localparam int unsigned REG_TARGET     = 1;

   localparam int unsigned STAT_BITS = 24;
   localparam int unsigned WLEN_BITS = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WRITE,
      ST_SUM,
      ST_DIV1,
      ST_SSQ,
      ST_DIV2,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start_clear;
      logic do_write;
      logic start_sum;
      logic start_div1;
      logic start_ssq;
      logic start_div2;
      logic start_sqrt;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic fold_done;
      logic full;
      logic sum_done;
      logic div_done;
      logic ssq_done;
      logic sqrt_done;
   } status_type;

endpackage

### hw/rtl/wms_stream_if.sv
interface wms_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [23:0] sample;
   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface wms_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [23:0] accuracy;
   logic [23:0] precision;
   modport source (output valid, output status, output accuracy, output precision,
                   input ready);
   modport sink   (input valid, input status, input accuracy, input precision,
                   output ready);
endinterface

### hw/rtl/wms_ram.sv
module wms_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/wms_ctrl.sv
module wms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wms_pkg::cmd_type    dp_cmd,
   input  wms_pkg::status_type dp_status
);
   import wms_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // A new word is taken once the previous result has left or is leaving.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == CMD_FLUSH_BIT) ? ST_CLEAR : ST_WRITE;
            end
         end
         ST_CLEAR: if (dp_status.clear_done) state_in = ST_OUT;
         ST_WRITE: state_in = dp_status.full ? ST_SUM : ST_OUT;
         ST_SUM:   if (dp_status.sum_done) state_in = ST_DIV1;
         ST_DIV1:  if (dp_status.div_done) state_in = ST_SSQ;
         ST_SSQ:   if (dp_status.ssq_done) state_in = ST_DIV2;
         ST_DIV2:  if (dp_status.div_done) state_in = ST_SQRT;
         ST_SQRT:  if (dp_status.sqrt_done) state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            dp_cmd.start_clear = accept && (req_cmd == CMD_FLUSH_BIT);
         end
         ST_WRITE: begin
            dp_cmd.do_write  = 1'b1;
            dp_cmd.start_sum = dp_status.full;
         end
         ST_SUM:  dp_cmd.start_div1 = dp_status.sum_done;
         ST_DIV1: dp_cmd.start_ssq  = dp_status.div_done;
         ST_SSQ:  dp_cmd.start_div2 = dp_status.ssq_done;
         ST_DIV2: dp_cmd.start_sqrt = dp_status.div_done;
         ST_OUT: begin
            dp_cmd.load_out = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### hw/rtl/wms_dp.sv
module wms_dp #(
   parameter int WINDOW_MAX  = 32,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_accept,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic [wms_pkg::WLEN_BITS-1:0]    cfg_window_len,
   input  logic [23:0]                      cfg_target,
   input  wms_pkg::cmd_type                 dp_cmd,
   output wms_pkg::status_type              dp_status,
   output logic                             rsp_status,
   output logic [23:0]                      rsp_accuracy,
   output logic [23:0]                      rsp_precision
);
   import wms_pkg::*;

   localparam int AW  = $clog2(WINDOW_MAX);
   localparam int NW  = $clog2(WINDOW_MAX + 1);
   localparam int SUMW = SAMPLE_BITS + NW;
   // Rounded up to an even width so that the root walks whole bit pairs.
   localparam int SSQW = ((2 * SAMPLE_BITS + NW + 1) / 2) * 2;
   localparam int RW   = SSQW / 2 + 1;
   localparam int SQW  = RW + 2;
   localparam int SQN  = (SSQW + 1) / 2;
   localparam int CW   = (SSQW > SQN ? $clog2(SSQW + 1) : $clog2(SQN + 1));

   // Effective window length, saturated to 2..WINDOW_MAX.
   logic [NW-1:0] n;
   always_comb begin
      if ({1'b0, cfg_window_len} < 7'd2) begin
         n = NW'(2);
      end else if (32'(cfg_window_len) > 32'(WINDOW_MAX)) begin
         n = NW'(WINDOW_MAX);
      end else begin
         n = NW'(cfg_window_len);
      end
   end

   // Ring state.
   logic [NW-1:0] start_ff, start_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [NW-1:0] s_mod, c_sat, waddr_w;
   logic [NW:0]   wsum;

   // A shortened window leaves start_ff folded down by n once a cycle while
   // idle, so it is already below n when the next word is written.
   always_comb begin
      s_mod = (start_ff >= n) ? (start_ff - n) : start_ff;
      c_sat = (fill_ff > n) ? n : fill_ff;
      wsum  = {1'b0, s_mod} + {1'b0, c_sat};
      waddr_w = (wsum >= {1'b0, n}) ? NW'(wsum - {1'b0, n}) : wsum[NW-1:0];
   end

   // Clearing pass.
   logic          clr_ff, clr_in;
   logic [NW-1:0] clr_idx_ff, clr_idx_in;

   // Pass over the ring (shared by sum and squared deviation).
   logic          pass_ff, pass_in;
   logic          ssq_mode_ff, ssq_mode_in;
   logic [NW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [NW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          rd_vld_ff;
   logic [NW-1:0] acc_cnt_ff, acc_cnt_in;
   logic [SSQW-1:0] acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0] d_ff;
   logic          d_vld_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;

   // Shared restoring divider.
   logic            div_ff, div_in;
   logic [SSQW-1:0] quo_ff, quo_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   dcnt_ff, dcnt_in;
   logic            div_done_ff;

   // Square root.
   logic            sq_ff, sq_in;
   logic [SSQW-1:0] sqv_ff, sqv_in;
   logic [RW-1:0]   sqr_ff, sqr_in;
   logic [CW-1:0]   scnt_ff, scnt_in;
   logic            sq_done_ff;

   logic                   ram_we;
   logic [AW-1:0]          ram_wa, ram_ra;
   logic [SAMPLE_BITS-1:0] ram_wd, ram_rd;

   wms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      ram_we = 1'b0;
      ram_wa = waddr_w[AW-1:0];
      ram_wd = sample_ff;
      if (clr_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_idx_ff[AW-1:0];
         ram_wd = '0;
      end else if (dp_cmd.do_write) begin
         ram_we = 1'b1;
      end
      ram_ra = rd_ptr_ff[AW-1:0];
   end

   // Ring update on clear, on write and on the fold of a shortened window.
   always_comb begin
      start_in = start_ff;
      fill_in  = fill_ff;
      if (dp_cmd.start_clear) begin
         start_in = '0;
         fill_in  = '0;
      end else if (dp_cmd.do_write) begin
         if (c_sat < n) begin
            start_in = s_mod;
            fill_in  = c_sat + NW'(1);
         end else begin
            start_in = (s_mod + NW'(1) == n) ? '0 : s_mod + NW'(1);
            fill_in  = c_sat;
         end
      end else if (start_ff >= n) begin
         start_in = start_ff - n;
      end
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (dp_cmd.start_clear) begin
         clr_in     = 1'b1;
         clr_idx_in = '0;
      end else if (clr_ff) begin
         clr_idx_in = clr_idx_ff + NW'(1);
         if (32'(clr_idx_ff) == WINDOW_MAX - 1) clr_in = 1'b0;
      end
   end

   // Pass: issue n reads starting at start_ff, accumulate as data returns.
   logic [SAMPLE_BITS-1:0] diff_w;
   always_comb begin
      pass_in     = pass_ff;
      ssq_mode_in = ssq_mode_ff;
      rd_cnt_in   = rd_cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      acc_cnt_in  = acc_cnt_ff;
      acc_in      = acc_ff;
      diff_w = (ram_rd >= mean_ff) ? ram_rd - mean_ff : mean_ff - ram_rd;
      if (dp_cmd.start_sum || dp_cmd.start_ssq) begin
         pass_in     = 1'b1;
         ssq_mode_in = dp_cmd.start_ssq;
         rd_cnt_in   = '0;
         rd_ptr_in   = dp_cmd.start_sum ? start_in : start_ff;
         acc_cnt_in  = '0;
         acc_in      = '0;
      end else if (pass_ff) begin
         if (rd_cnt_ff != n) begin
            rd_cnt_in = rd_cnt_ff + NW'(1);
            rd_ptr_in = (rd_ptr_ff + NW'(1) == n) ? '0 : rd_ptr_ff + NW'(1);
         end
         if (!ssq_mode_ff && rd_vld_ff) begin
            acc_in     = acc_ff + SSQW'(ram_rd);
            acc_cnt_in = acc_cnt_ff + NW'(1);
         end
         if (ssq_mode_ff && d_vld_ff) begin
            acc_in     = acc_ff + SSQW'(d_ff) * SSQW'(d_ff);
            acc_cnt_in = acc_cnt_ff + NW'(1);
         end
         if (acc_cnt_in == n) pass_in = 1'b0;
      end
   end

   // Divider: acc_ff / n, one quotient bit per cycle.
   logic [NW:0] trial;
   always_comb begin
      div_in  = div_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      trial   = {rem_ff, quo_ff[SSQW-1]};
      if (dp_cmd.start_div1 || dp_cmd.start_div2) begin
         div_in  = 1'b1;
         quo_in  = acc_ff;
         rem_in  = '0;
         dcnt_in = CW'(SSQW);
      end else if (div_ff) begin
         quo_in = {quo_ff[SSQW-2:0], 1'b0};
         if (trial >= {1'b0, n}) begin
            rem_in    = NW'(trial - {1'b0, n});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[NW-1:0];
         end
         dcnt_in = dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) div_in = 1'b0;
      end
   end

   // Square root, two radicand bits per cycle.
   logic [SQW-1:0] sq_t;
   logic [SQW-1:0] sq_rem;
   logic [RW-1:0]  sqrem_ff, sqrem_in_unused;
   always_comb begin
      sq_in   = sq_ff;
      sqv_in  = sqv_ff;
      sqr_in  = sqr_ff;
      scnt_in = scnt_ff;
      sqrem_in_unused = sqrem_ff;
      sq_rem = {sqrem_ff, sqv_ff[SSQW-1 -: 2]};
      sq_t   = {sqr_ff, 2'b01};
      if (dp_cmd.start_sqrt) begin
         sq_in   = 1'b1;
         sqv_in  = quo_ff;
         sqr_in  = '0;
         sqrem_in_unused = '0;
         scnt_in = CW'(SQN);
      end else if (sq_ff) begin
         sqv_in = {sqv_ff[SSQW-3:0], 2'b00};
         if (sq_rem >= sq_t) begin
            sqrem_in_unused = RW'(sq_rem - sq_t);
            sqr_in = {sqr_ff[RW-2:0], 1'b1};
         end else begin
            sqrem_in_unused = RW'(sq_rem);
            sqr_in = {sqr_ff[RW-2:0], 1'b0};
         end
         scnt_in = scnt_ff - CW'(1);
         if (scnt_ff == CW'(1)) sq_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         fill_ff     <= '0;
         clr_ff      <= 1'b1;
         clr_idx_ff  <= '0;
         pass_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         d_vld_ff    <= 1'b0;
         div_ff      <= 1'b0;
         div_done_ff <= 1'b0;
         sq_ff       <= 1'b0;
         sq_done_ff  <= 1'b0;
      end else begin
         start_ff    <= start_in;
         fill_ff     <= fill_in;
         clr_ff      <= clr_in;
         clr_idx_ff  <= clr_idx_in;
         pass_ff     <= pass_in;
         rd_vld_ff   <= pass_ff && (rd_cnt_ff != n) && !dp_cmd.start_ssq;
         d_vld_ff    <= rd_vld_ff && ssq_mode_ff && pass_ff;
         div_ff      <= div_in;
         div_done_ff <= div_ff && !div_in;
         sq_ff       <= sq_in;
         sq_done_ff  <= sq_ff && !sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) sample_ff <= req_sample;
      ssq_mode_ff <= ssq_mode_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_ptr_ff   <= rd_ptr_in;
      acc_cnt_ff  <= acc_cnt_in;
      acc_ff      <= acc_in;
      d_ff        <= diff_w;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      sqv_ff      <= sqv_in;
      sqr_ff      <= sqr_in;
      sqrem_ff    <= sqrem_in_unused;
      scnt_ff     <= scnt_in;
      if (dp_cmd.start_ssq) mean_ff <= SAMPLE_BITS'(quo_ff);
   end

   // Result register.
   logic        status_ff;
   logic [23:0] accuracy_ff, precision_ff;
   logic        full_ff;
   always_ff @(posedge clock) begin
      if (dp_cmd.do_write) full_ff <= !(c_sat < n) || (c_sat + NW'(1) == n);
      if (dp_cmd.start_clear) full_ff <= 1'b0;
      if (dp_cmd.load_out) begin
         status_ff <= full_ff;
         if (full_ff) begin
            accuracy_ff  <= (mean_ff >= SAMPLE_BITS'(cfg_target)) ?
                            24'(mean_ff - SAMPLE_BITS'(cfg_target)) :
                            24'(SAMPLE_BITS'(cfg_target) - mean_ff);
            precision_ff <= 24'(sqr_ff);
         end else begin
            accuracy_ff  <= '0;
            precision_ff <= '0;
         end
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_accuracy  = accuracy_ff;
   assign rsp_precision = precision_ff;

   always_comb begin
      dp_status.clear_done = !clr_ff;
      dp_status.fold_done  = !(start_ff >= n);
      dp_status.full       = !(c_sat < n) || (c_sat + NW'(1) == n);
      dp_status.sum_done   = !pass_ff && !ssq_mode_ff && !dp_cmd.start_sum;
      dp_status.ssq_done   = !pass_ff && ssq_mode_ff && !dp_cmd.start_ssq;
      dp_status.div_done   = div_done_ff;
      dp_status.sqrt_done  = sq_done_ff;
   end
endmodule

### hw/rtl/window_mean_sigma_stats_unit.sv
// Sliding-window statistics over unsigned Q16.8 samples. Each add word
// stores a sample in a ring held in a single-port-write RAM; once the window
// holds window_len samples (saturated to 2..WINDOW_MAX) the result carries
// |mean - target| and the floored population standard deviation. A full
// window of n samples gives its result after two read passes over the ring,
// two bit-serial divisions by n, a two-bit-per-cycle square root and the
// sequencing between them; no new word is taken until that result has left
// or is leaving. An add while the window is filling passes only through the
// write and output states, and a flush zeroes the ring one entry a cycle.
// After reset the same clearing pass runs before the first word is taken,
// and after window_len is shortened the block holds off the next word while
// it folds the ring start into the new window.
module window_mean_sigma_stats_unit #(
   parameter int WINDOW_MAX  = 32,
   parameter int SAMPLE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   wms_req_if.sink     req,
   wms_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wms_pkg::*;

   logic [WLEN_BITS-1:0] window_len_ff;
   logic [23:0]          target_ff;
   cmd_type              dp_cmd;
   status_type           dp_status;
   logic                 req_ready_w;
   logic                 dp_busy;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WLEN_BITS'(8);
         target_ff     <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_TARGET[0]) begin
            target_ff <= csr_pwdata[23:0];
         end else begin
            window_len_ff <= csr_pwdata[WLEN_BITS-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = (csr_paddr[2] == REG_TARGET[0]) ? {8'd0, target_ff} :
                   {26'd0, window_len_ff};
   end

   assign dp_busy   = !dp_status.clear_done || !dp_status.fold_done;
   assign req.ready = req_ready_w && !dp_busy;

   wms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid && !dp_busy),
      .req_ready (req_ready_w),
      .req_cmd   (req.cmd),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   wms_dp #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req.valid && req.ready),
      .req_sample     (SAMPLE_BITS'(req.sample)),
      .cfg_window_len (window_len_ff),
      .cfg_target     (target_ff),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .rsp_status     (rsp.status),
      .rsp_accuracy   (rsp.accuracy),
      .rsp_precision  (rsp.precision)
   );
endmodule
